[hdl/cpmm_pkg.sv]
// ----------------------------------------------------------------------------
// cpmm_pkg: shared types and constants
// Widths, saturation limits and the sequencer state type for the
// cardinality potential max-marginals block.
// ----------------------------------------------------------------------------
package cpmm_pkg;

  localparam int unsigned CostW = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned SumW  = 48;
  localparam int unsigned KW    = 7;

  localparam logic signed [SumW-1:0] SatMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic signed [DiffW-1:0] DiffTop = {1'b0, {(DiffW-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_SUM,
    ST_RANK,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // saturate a 64-bit signed value to 48 bits
  function automatic logic signed [SumW-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(SatMax);
    lo = 64'(SatMin);
    if (v > hi) begin
      sat48 = SatMax;
    end else if (v < lo) begin
      sat48 = SatMin;
    end else begin
      sat48 = v[SumW-1:0];
    end
  endfunction

endpackage

[hdl/cardinality_potential_max_marginals.sv]
// ----------------------------------------------------------------------------
// cardinality_potential_max_marginals: top-K cardinality min-marginals
// Loads binary variables, keeps their on-minus-off differences sorted, and
// after the last item, or once the store is full, emits one min-marginal result per variable.
// ----------------------------------------------------------------------------
// Each item's new difference is inserted into a sorted list held in a
// memory with a registered read port, one entry moved per cycle. At the
// end of a run the block sums the chosen differences, builds the rank map
// and then emits one result per variable, never back to back, with busy
// high throughout. Results appear as one-cycle strobes and must be taken as
// they come; the receiver cannot stall them.
module cardinality_potential_max_marginals #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           cost_off,
  input  logic signed [31:0]           cost_on,
  input  logic                         final_item,
  input  logic                         cfg_we,
  input  logic [6:0]                   cfg_wdata,
  output logic                         strobe,
  output logic signed [47:0]           marginal_off,
  output logic signed [47:0]           marginal_on,
  output logic signed [47:0]           total_energy,
  output logic                         run_end,
  output logic                         too_few_items
);
  import cpmm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);

  state_t state, state_next;

  // memories
  logic [63:0]             cost_mem [MAX_ITEMS];
  logic signed [DiffW-1:0] rank_d   [MAX_ITEMS];
  logic [AW-1:0]           rank_i   [MAX_ITEMS];
  logic [AW-1:0]           rank_of  [MAX_ITEMS];

  logic [KW-1:0]           k_reg;
  logic [IW-1:0]           count;
  logic signed [SumW-1:0]  off_sum;
  logic [IW-1:0]           pos;
  logic signed [DiffW-1:0] new_d;
  logic                    fin_hold;
  logic [IW-1:0]           kk;
  logic [IW-1:0]           scan;
  logic signed [63:0]      acc;
  logic signed [DiffW-1:0] d_k, d_km1;
  logic signed [SumW-1:0]  total;
  logic [63:0]             c_rd;
  logic [AW-1:0]           ro_rd;
  logic                    head_new;
  logic signed [DiffW-1:0] sum_d;

  // rank list read port (registered)
  logic [AW-1:0]           rl_addr;
  logic signed [DiffW-1:0] rl_d;
  logic [AW-1:0]           rl_i;

  // control decode
  logic accept;
  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;

  // entry zero written at the edge that entered the sum comes from new_d
  assign sum_d = (scan == '0 && head_new) ? new_d : rl_d;

  always_comb begin
    state_next = state;
    rl_addr    = '0;
    case (state)
      ST_LOAD: begin
        rl_addr = (count == '0) ? '0 : AW'(count - 1'b1);
        if (accept) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        rl_addr = (pos > IW'(1)) ? AW'(pos - IW'(2)) : '0;
        if (pos == '0 || rl_d <= new_d) begin
          rl_addr    = '0;
          state_next = (fin_hold || count == IW'(MAX_ITEMS - 1)) ? ST_SUM : ST_LOAD;
        end
      end
      ST_SUM: begin
        rl_addr = (scan + 1'b1 >= kk) ? '0 : AW'(scan + 1'b1);
        if (scan + 1'b1 >= kk) begin
          state_next = ST_RANK;
        end
      end
      ST_RANK: begin
        rl_addr = AW'(scan + 1'b1);
        if (scan + 1'b1 >= count) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = (scan + 1'b1 >= count) ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // rank list read
  always_ff @(posedge clk) begin
    rl_d <= rank_d[rl_addr];
    rl_i <= rank_i[rl_addr];
  end

  // cost store and rank map reads
  always_ff @(posedge clk) begin
    c_rd  <= cost_mem[AW'(scan)];
    ro_rd <= rank_of[AW'(scan)];
  end

  // main datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      k_reg   <= KW'(1);
      count   <= '0;
      off_sum <= '0;
      strobe  <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (cfg_we) begin
        k_reg <= cfg_wdata;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            cost_mem[AW'(count)] <= {cost_on, cost_off};
            new_d    <= DiffW'(cost_on) - DiffW'(cost_off);
            fin_hold <= final_item;
            pos      <= count;
            off_sum  <= sat48(64'(off_sum) + 64'(cost_off));
          end
        end
        ST_SHIFT: begin
          // rl_d holds entry pos-1
          if (pos == '0 || rl_d <= new_d) begin
            rank_d[AW'(pos)] <= new_d;
            rank_i[AW'(pos)] <= AW'(count);
            count    <= count + 1'b1;
            scan     <= '0;
            acc      <= 64'(off_sum);
            head_new <= (pos == '0);
            if (k_reg == '0) begin
              kk <= IW'(1);
            end else if (k_reg > KW'(MAX_ITEMS)) begin
              kk <= IW'(MAX_ITEMS);
            end else begin
              kk <= IW'(k_reg);
            end
          end else begin
            rank_d[AW'(pos)] <= rl_d;
            rank_i[AW'(pos)] <= rl_i;
            pos <= pos - 1'b1;
          end
        end
        ST_SUM: begin
          // sum_d holds entry scan
          if (scan < count) begin
            acc <= acc + 64'(sum_d);
          end
          if (scan + 1'b1 == kk) begin
            d_km1 <= sum_d;
          end
          if (scan == kk) begin
            d_k <= sum_d;
          end
          if (scan + 1'b1 >= kk) begin
            scan <= '0;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_RANK: begin
          if (scan == '0) begin
            total <= sat48(acc);
          end
          rank_of[rl_i] <= AW'(scan);
          if (scan + 1'b1 == kk) begin
            d_km1 <= rl_d;
          end
          if (scan == kk) begin
            d_k <= rl_d;
          end
          scan <= (scan + 1'b1 >= count) ? '0 : scan + 1'b1;
        end
        ST_EMIT_RD: begin
        end
        ST_EMIT: begin
          strobe        <= 1'b1;
          total_energy  <= total;
          run_end       <= (scan + 1'b1 == count);
          too_few_items <= (count < kk);
          if (IW'(ro_rd) < kk) begin
            marginal_on  <= total;
            marginal_off <= (kk < count) ?
              sat48(64'(total) + 64'(d_k)
                    - (64'($signed(c_rd[63:32])) - 64'($signed(c_rd[31:0]))))
              : SatMax;
          end else begin
            marginal_off <= total;
            marginal_on  <= sat48(64'(total) - 64'(d_km1)
                    + (64'($signed(c_rd[63:32])) - 64'($signed(c_rd[31:0]))));
          end
          scan <= scan + 1'b1;
          if (scan + 1'b1 >= count) begin
            count   <= '0;
            off_sum <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/cpmm_checker.sv]
// ----------------------------------------------------------------------------
// cpmm_checker: port-level checks
// Watches the command and result ports of the top level.
// ----------------------------------------------------------------------------
module cpmm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input logic               run_end,
  input logic signed [47:0] marginal_off,
  input logic signed [47:0] marginal_on,
  input logic signed [47:0] total_energy
);
  // an accepted item always makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");

  // results are never back to back
  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobes adjacent");

  // one side of each result equals the total
  a_total_side: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (marginal_off == total_energy || marginal_on == total_energy))
    else $error("no side equals total");

  // busy is already low when the last result is strobed
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && run_end) |-> !busy) else $error("busy after run end");

endmodule

bind cardinality_potential_max_marginals cpmm_checker u_cpmm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .run_end(run_end), .marginal_off(marginal_off), .marginal_on(marginal_on),
  .total_energy(total_energy)
);
